### src/cdq_pkg.sv
// types and constants shared by the circular deque modules
`default_nettype none

package cdq_pkg;

  localparam int unsigned DataW = 32;

  // operation codes
  localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DataW-1:0] push_value;
  } cdq_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] pop_value;
    logic [1:0]              status;
  } cdq_out_t;

  // registered response info from the controller
  typedef struct packed {
    logic       done;
    logic       pop_ok;
    logic [1:0] status;
  } cdq_resp_t;

endpackage

`default_nettype wire

### src/cdq_ram.sv
// slot storage: one write port, one read port with registered read data
`default_nettype none

module cdq_ram
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  wire logic                    clk_i,
  input  wire logic                    wr_en_i,
  input  wire logic [AW-1:0]           wr_addr_i,
  input  wire logic signed [DataW-1:0] wr_data_i,
  input  wire logic                    rd_en_i,
  input  wire logic [AW-1:0]           rd_addr_i,
  output logic signed [DataW-1:0]      rd_data_o
);

  logic signed [DataW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### src/cdq_ctrl.sv
// head, tail and occupancy tracking, memory access generation, status
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2,
  parameter int unsigned CW    = 3
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    accept_i,
  input  wire logic [1:0] op_i,
  output logic         wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic         rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  output cdq_resp_t    resp_o
);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  cdq_resp_t     resp_q, resp_d;

  logic [AW-1:0] head_up, head_dn, tail_up, tail_dn;
  logic          is_full, is_empty;

  assign head_up  = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign head_dn  = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign tail_up  = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
  assign tail_dn  = (tail_q == '0) ? LastIdx : tail_q - AW'(1);
  assign is_full  = (count_q == Full);
  assign is_empty = (count_q == '0);

  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    wr_en_o        = 1'b0;
    wr_addr_o      = tail_q;
    rd_en_o        = 1'b0;
    rd_addr_o      = head_q;
    resp_d.done    = accept_i;
    resp_d.pop_ok  = 1'b0;
    resp_d.status  = ST_OK;
    if (accept_i) begin
      case (op_i)
        OP_PUSH_REAR: begin
          if (is_full) begin
            resp_d.status = ST_OVERFLOW;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = tail_q;
            tail_d    = tail_up;
            count_d   = count_q + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            resp_d.status = ST_OVERFLOW;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = head_dn;
            head_d    = head_dn;
            count_d   = count_q + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            resp_d.status = ST_UNDERFLOW;
          end else begin
            rd_en_o       = 1'b1;
            rd_addr_o     = head_q;
            head_d        = head_up;
            count_d       = count_q - CW'(1);
            resp_d.pop_ok = 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (is_empty) begin
            resp_d.status = ST_UNDERFLOW;
          end else begin
            rd_en_o       = 1'b1;
            rd_addr_o     = tail_dn;
            tail_d        = tail_dn;
            count_d       = count_q - CW'(1);
            resp_d.pop_ok = 1'b1;
          end
        end
        default: begin
          resp_d.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      resp_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      resp_q  <= resp_d;
    end
  end

  assign resp_o = resp_q;

endmodule

`default_nettype wire

### src/circular_deque_top.sv
// circular double-ended queue: result strobed on done_o the cycle after start
// throughput one word per cycle; busy_o stays low, pointers update at accept and the slot
// memory is read at the same edge, so a following word always sees the previous write
// the receiver cannot stall, so every result shows for exactly one cycle
// reset clears head, tail, occupancy and the result strobe; slot contents are left as is
`default_nettype none

module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire cdq_in_t cmd_i,
  output logic         busy_o,
  output logic         done_o,
  output cdq_out_t     result_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                    accept;
  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic signed [DataW-1:0] rd_data;
  cdq_resp_t               resp;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  cdq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (cmd_i.op),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .resp_o   (resp)
  );

  cdq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(cmd_i.push_value),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign done_o             = resp.done;
  assign result_o.pop_value = resp.pop_ok ? rd_data : '0;
  assign result_o.status    = resp.status;

  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result after accepted word");

  a_no_spurious_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without accepted word");

  a_push_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i.op == OP_PUSH_REAR || cmd_i.op == OP_PUSH_FRONT)
    |=> result_o.pop_value == '0 && result_o.status != ST_UNDERFLOW)
    else $error("push result carries data or underflow");

endmodule

`default_nettype wire
